FILE: rtl/core/avnt_pkg.sv
package avnt_pkg;

  // field widths
  localparam int POS_W  = 32;
  localparam int NRM_W  = 16;
  localparam int COEF_W = 16;
  localparam int ROW_W  = 3 * COEF_W;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = ROW_W;

  // internal normal path widths
  localparam int V_W    = 28;
  localparam int SQ_W   = 54;
  localparam int LEN_W  = 27;
  localparam int Q_W    = 15;
  localparam int NUM_W  = 44;

  // squared length floor, 0.000001 in Q.40
  localparam logic [SQ_W-1:0] NRM_MIN_SQ = SQ_W'(1099512);

  // register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_ROW_X = 3'd0,
    REG_ROW_Y = 3'd1,
    REG_ROW_Z = 3'd2,
    REG_OFF_X = 3'd3,
    REG_OFF_Y = 3'd4,
    REG_OFF_Z = 3'd5
  } cfg_idx_t;

  // reset values of the linear part (identity)
  localparam logic [ROW_W-1:0] ROW_X_RST = ROW_W'(48'h0000_0000_1000);
  localparam logic [ROW_W-1:0] ROW_Y_RST = ROW_W'(48'h0000_1000_0000);
  localparam logic [ROW_W-1:0] ROW_Z_RST = ROW_W'(48'h1000_0000_0000);

  // position result plus transformed normal
  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [2:0][V_W-1:0]   v;
  } vec_t;

  // vec plus squared length
  typedef struct packed {
    vec_t            d;
    logic [SQ_W-1:0] sq;
  } mid_t;

endpackage

FILE: rtl/core/avnt_if.sv
interface avnt_in_if;
  import avnt_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pos_in_x;
  logic [POS_W-1:0] pos_in_y;
  logic [POS_W-1:0] pos_in_z;
  logic [NRM_W-1:0] nrm_in_x;
  logic [NRM_W-1:0] nrm_in_y;
  logic [NRM_W-1:0] nrm_in_z;
  modport source (output valid, pos_in_x, pos_in_y, pos_in_z,
                  nrm_in_x, nrm_in_y, nrm_in_z, input ready);
  modport sink (input valid, pos_in_x, pos_in_y, pos_in_z,
                nrm_in_x, nrm_in_y, nrm_in_z, output ready);
endinterface

interface avnt_out_if;
  import avnt_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pos_out_x;
  logic [POS_W-1:0] pos_out_y;
  logic [POS_W-1:0] pos_out_z;
  logic [NRM_W-1:0] nrm_out_x;
  logic [NRM_W-1:0] nrm_out_y;
  logic [NRM_W-1:0] nrm_out_z;
  modport source (output valid, pos_out_x, pos_out_y, pos_out_z,
                  nrm_out_x, nrm_out_y, nrm_out_z, input ready);
  modport sink (input valid, pos_out_x, pos_out_y, pos_out_z,
                nrm_out_x, nrm_out_y, nrm_out_z, output ready);
endinterface

interface avnt_cfg_if;
  import avnt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

FILE: rtl/core/avnt_front.sv
module avnt_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [2:0][avnt_pkg::POS_W-1:0] p_in,
  input  logic [2:0][avnt_pkg::NRM_W-1:0] n_in,
  input  logic [2:0][avnt_pkg::ROW_W-1:0] rows,
  input  logic [2:0][avnt_pkg::POS_W-1:0] offs,
  output logic                            out_vld,
  output avnt_pkg::mid_t                  out_mid
);
  import avnt_pkg::*;

  logic [3:0]                vld_r;
  logic signed [47:0]        pp_r [3][3];
  logic signed [31:0]        np_r [3][3];
  logic signed [37:0]        pr_r [3];
  logic signed [V_W-1:0]     v2_r [3];
  logic [2:0][POS_W-1:0]     po_r;
  logic [2:0][V_W-1:0]       v3_r;
  logic [SQ_W-1:0]           sqv_r [3];
  mid_t                      mid_r;

  logic signed [49:0]        psum [3];
  logic signed [33:0]        nsum [3];
  logic signed [38:0]        ps   [3];
  logic [SQ_W-1:0]           sq_sum;

  // valid bits travel with the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pp_r[r][c] <= $signed(rows[r][COEF_W*c +: COEF_W]) * $signed(p_in[c]);
          np_r[r][c] <= $signed(rows[r][COEF_W*c +: COEF_W]) * $signed(n_in[c]);
        end
      end
    end
  end

  // stage 2: dot products and rounding
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      psum[r] = 50'(pp_r[r][0]) + 50'(pp_r[r][1]) + 50'(pp_r[r][2]);
      nsum[r] = 34'(np_r[r][0]) + 34'(np_r[r][1]) + 34'(np_r[r][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        pr_r[r] <= 38'((psum[r] + 50'sd2048) >>> 12);
        v2_r[r] <= V_W'((nsum[r] + 34'sd32) >>> 6);
      end
    end
  end

  // stage 3: offset with saturation, squares
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      ps[r] = 39'(pr_r[r]) + 39'($signed(offs[r]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        if (ps[r][38:31] == '0 || ps[r][38:31] == '1) begin
          po_r[r] <= ps[r][31:0];
        end else if (ps[r][38]) begin
          po_r[r] <= 32'h8000_0000;
        end else begin
          po_r[r] <= 32'h7fff_ffff;
        end
        v3_r[r]  <= v2_r[r];
        sqv_r[r] <= SQ_W'(v2_r[r] * v2_r[r]);
      end
    end
  end

  // stage 4: squared length with floor
  assign sq_sum = sqv_r[0] + sqv_r[1] + sqv_r[2];

  always_ff @(posedge clk) begin
    if (en) begin
      mid_r.d.pos <= po_r;
      mid_r.d.v   <= v3_r;
      mid_r.sq    <= (sq_sum < NRM_MIN_SQ) ? NRM_MIN_SQ : sq_sum;
    end
  end

  assign out_vld = vld_r[3];
  assign out_mid = mid_r;

endmodule

FILE: rtl/core/avnt_sqrt.sv
module avnt_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  avnt_pkg::mid_t              in_mid,
  output logic                        out_vld,
  output avnt_pkg::vec_t              out_d,
  output logic [avnt_pkg::LEN_W-1:0]  out_len
);
  import avnt_pkg::*;

  logic              vld_r [LEN_W+1];
  logic [SQ_W:0]     rem_r [LEN_W+1];
  logic [LEN_W-1:0]  res_r [LEN_W+1];
  vec_t              d_r   [LEN_W+1];

  // stage zero is the incoming item
  assign vld_r[0] = in_vld;
  assign rem_r[0] = (SQ_W+1)'(in_mid.sq);
  assign res_r[0] = '0;
  assign d_r[0]   = in_mid.d;

  // one result bit per stage, msb first
  for (genvar k = 0; k < LEN_W; k++) begin : g_bit
    localparam int B = LEN_W - 1 - k;
    logic [SQ_W:0] trial;
    logic          take;

    assign trial = ((SQ_W+1)'(res_r[k]) << (B + 1)) | ((SQ_W+1)'(1) << (2 * B));
    assign take  = (rem_r[k] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? (rem_r[k] - trial) : rem_r[k];
        res_r[k+1] <= take ? (res_r[k] | (LEN_W'(1) << B)) : res_r[k];
        d_r[k+1]   <= d_r[k];
      end
    end
  end

  assign out_vld = vld_r[LEN_W];
  assign out_d   = d_r[LEN_W];
  assign out_len = res_r[LEN_W];

endmodule

FILE: rtl/core/avnt_div.sv
module avnt_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  avnt_pkg::vec_t                  in_d,
  input  logic [avnt_pkg::LEN_W-1:0]      in_len,
  output logic                            out_vld,
  output logic [2:0][avnt_pkg::POS_W-1:0] out_pos,
  output logic [2:0][avnt_pkg::NRM_W-1:0] out_nrm
);
  import avnt_pkg::*;

  logic                    vld_r [Q_W+1];
  logic [2:0][NUM_W-1:0]   rem_r [Q_W+1];
  logic [2:0][Q_W-1:0]     q_r   [Q_W+1];
  logic [2:0]              neg_r [Q_W+1];
  logic [NUM_W-1:0]        den_r [Q_W+1];
  logic [2:0][POS_W-1:0]   pos_r [Q_W+1];
  logic [2:0][V_W-1:0]     mag;

  // set up magnitude and rounding term per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]      = in_d.v[i][V_W-1] ? (V_W'(0) - in_d.v[i]) : in_d.v[i];
      rem_r[0][i] = (NUM_W'(mag[i]) << Q_W) + NUM_W'(in_len);
      q_r[0][i]   = '0;
      neg_r[0][i] = in_d.v[i][V_W-1];
    end
  end

  assign vld_r[0] = in_vld;
  assign den_r[0] = NUM_W'(in_len) << 1;
  assign pos_r[0] = in_d.pos;

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < Q_W; k++) begin : g_bit
    localparam int B = Q_W - 1 - k;
    logic [NUM_W-1:0] dsh;

    assign dsh = den_r[k] << B;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_r[k][i] >= dsh) begin
            rem_r[k+1][i] <= rem_r[k][i] - dsh;
            q_r[k+1][i]   <= q_r[k][i] | (Q_W'(1) << B);
          end else begin
            rem_r[k+1][i] <= rem_r[k][i];
            q_r[k+1][i]   <= q_r[k][i];
          end
        end
        neg_r[k+1] <= neg_r[k];
        den_r[k+1] <= den_r[k];
        pos_r[k+1] <= pos_r[k];
      end
    end
  end

  // signed result from the last stage
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_nrm[i] = neg_r[Q_W][i] ? (NRM_W'(0) - NRM_W'(q_r[Q_W][i]))
                                 : NRM_W'(q_r[Q_W][i]);
    end
  end

  assign out_vld = vld_r[Q_W];
  assign out_pos = pos_r[Q_W];

endmodule

FILE: rtl/core/affine_vertex_normal_transform.sv
// throughput: one vertex per cycle while out_bus takes results; 4 arithmetic
// stages, 27 square-root stages and 15 divider stages, the last of which is
// the output register
// the whole pipeline holds while a result waits on out_bus
// reset: synchronous active-low rst_n clears all valid bits and loads the
// identity matrix and zero translation
module affine_vertex_normal_transform (
  input  logic         clk,
  input  logic         rst_n,
  avnt_in_if.sink      in_bus,
  avnt_out_if.source   out_bus,
  avnt_cfg_if.sink     cfg_bus
);
  import avnt_pkg::*;

  logic [2:0][ROW_W-1:0] rows_r;
  logic [2:0][POS_W-1:0] offs_r;
  logic                  en;
  logic                  f_vld;
  mid_t                  f_mid;
  logic                  s_vld;
  vec_t                  s_d;
  logic [LEN_W-1:0]      s_len;
  logic                  d_vld;
  logic [2:0][POS_W-1:0] d_pos;
  logic [2:0][NRM_W-1:0] d_nrm;

  // configuration registers
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= {ROW_Z_RST, ROW_Y_RST, ROW_X_RST};
      offs_r <= '0;
    end else if (cfg_bus.valid) begin
      case (cfg_idx_t'(cfg_bus.addr))
        REG_ROW_X: rows_r[0] <= cfg_bus.data;
        REG_ROW_Y: rows_r[1] <= cfg_bus.data;
        REG_ROW_Z: rows_r[2] <= cfg_bus.data;
        REG_OFF_X: offs_r[0] <= cfg_bus.data[POS_W-1:0];
        REG_OFF_Y: offs_r[1] <= cfg_bus.data[POS_W-1:0];
        REG_OFF_Z: offs_r[2] <= cfg_bus.data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless a result is stalled at the output
  assign en           = !d_vld || out_bus.ready;
  assign in_bus.ready = en;

  avnt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_bus.valid),
    .p_in    ({in_bus.pos_in_z, in_bus.pos_in_y, in_bus.pos_in_x}),
    .n_in    ({in_bus.nrm_in_z, in_bus.nrm_in_y, in_bus.nrm_in_x}),
    .rows    (rows_r),
    .offs    (offs_r),
    .out_vld (f_vld),
    .out_mid (f_mid)
  );

  avnt_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (f_vld),
    .in_mid  (f_mid),
    .out_vld (s_vld),
    .out_d   (s_d),
    .out_len (s_len)
  );

  avnt_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s_vld),
    .in_d    (s_d),
    .in_len  (s_len),
    .out_vld (d_vld),
    .out_pos (d_pos),
    .out_nrm (d_nrm)
  );

  // result channel
  assign out_bus.valid     = d_vld;
  assign out_bus.pos_out_x = d_pos[0];
  assign out_bus.pos_out_y = d_pos[1];
  assign out_bus.pos_out_z = d_pos[2];
  assign out_bus.nrm_out_x = d_nrm[0];
  assign out_bus.nrm_out_y = d_nrm[1];
  assign out_bus.nrm_out_z = d_nrm[2];

endmodule

FILE: rtl/core/avnt_checker.sv
module avnt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [avnt_pkg::NRM_W-1:0]  nrm_out_x,
  input logic [avnt_pkg::NRM_W-1:0]  nrm_out_z
);
  import avnt_pkg::*;

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input side stalls only behind a stalled result
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // x and z unit normal components stay within one
  a_nrm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(nrm_out_x) <= 16'sd16384 && $signed(nrm_out_x) >= -16'sd16384
                   && $signed(nrm_out_z) <= 16'sd16384 && $signed(nrm_out_z) >= -16'sd16384))
    else $error("normal component out of range");

endmodule

bind affine_vertex_normal_transform avnt_checker u_avnt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .nrm_out_x (out_bus.nrm_out_x),
  .nrm_out_z (out_bus.nrm_out_z)
);

FILE: verif/affine_vertex_normal_transform_tb.sv
module affine_vertex_normal_transform_tb;
  import avnt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // index with no register behind it, writes there must be dropped
  localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd6;
  localparam int QUIET_CYCLES = 60;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;

  typedef enum logic [1:0] {REQ_VERTEX, REQ_CFG, REQ_DRAIN} req_kind_t;

  typedef struct {
    logic signed [POS_W-1:0] pos[3];
    logic signed [NRM_W-1:0] nrm[3];
  } vertex_t;

  typedef struct {
    req_kind_t         kind;
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] data;
    vertex_t           vtx;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  avnt_in_if  in_bus();
  avnt_out_if out_bus();
  avnt_cfg_if cfg_bus();

  affine_vertex_normal_transform dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus), .cfg_bus(cfg_bus)
  );

  always #5 clk = ~clk;

  // shadow copy of the transform registers
  logic [ROW_W-1:0]        mat_rows[3];
  logic signed [POS_W-1:0] translation[3];

  request_t pending_reqs[$];
  vertex_t  expected_vertices[$];

  int errors = 0;
  int vertices_sent = 0;
  int vertices_checked = 0;
  int cfg_writes = 0;
  int clamped_positions = 0;
  int floored_normals = 0;
  int stall_phase = 0;
  bit stim_done = 1'b0;
  bit in_acc = 1'b0;
  bit cfg_acc = 1'b0;
  bit hold_done = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // expected transformed vertex under the current register settings
  function automatic vertex_t transform_vertex(vertex_t a);
    vertex_t o;
    longint c, acc_p, acc_n, r, mag_s;
    longint v[3];
    longint unsigned sq, len, q;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      acc_p = 0;
      acc_n = 0;
      for (int k = 0; k < 3; k++) begin
        c = longint'($signed(mat_rows[i][COEF_W*k +: COEF_W]));
        acc_p += c * longint'(a.pos[k]);
        acc_n += c * longint'(a.nrm[k]);
      end
      r = ((acc_p + 2048) >>> 12) + longint'(translation[i]);
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647;
        clamped_positions++;
      end else if (r < -64'sd2147483648) begin
        r = -64'sd2147483648;
        clamped_positions++;
      end
      o.pos[i] = r[POS_W-1:0];
      v[i] = (acc_n + 32) >>> 6;
      sq += longint'(v[i] * v[i]);
    end
    if (sq < 64'd1099512) begin
      sq = 64'd1099512;
      floored_normals++;
    end
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      mag_s = (v[i] < 0) ? -v[i] : v[i];
      q = (longint'(mag_s) * 32768 + len) / (2 * len);
      o.nrm[i] = (v[i] < 0) ? -q[NRM_W-1:0] : q[NRM_W-1:0];
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= 40)
      $display("mismatch on result %0d: %s got %0d want %0d", vertices_checked, what, got, want);
  endtask

  // idle length: none in the last stretch, else mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (stall_phase == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [15:0] rand_nrm_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($signed($urandom_range(0, 32768)) - 16384);
    if (r < 8) return 16'($signed($urandom_range(0, 200)) - 100);
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] rand_pos_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
    if (r < 9) return 32'($urandom);
    return (r[0]) ? 32'h7fff_ffff : 32'h8000_0000;
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef(int style);
    case (style)
      0: return 16'($signed($urandom_range(0, 8192)) - 4096);
      1: return 16'($urandom);
      default: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  task automatic queue_vertex(logic [31:0] px, py, pz, logic [15:0] nx, ny, nz);
    request_t q;
    q.kind = REQ_VERTEX;
    q.addr = '0;
    q.data = '0;
    q.vtx.pos[0] = px; q.vtx.pos[1] = py; q.vtx.pos[2] = pz;
    q.vtx.nrm[0] = nx; q.vtx.nrm[1] = ny; q.vtx.nrm[2] = nz;
    pending_reqs.insert(pending_reqs.size(), q);
  endtask

  task automatic queue_cfg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    request_t q;
    q.kind = REQ_CFG;
    q.addr = addr;
    q.data = data;
    pending_reqs.insert(pending_reqs.size(), q);
  endtask

  task automatic queue_drain();
    request_t q;
    q.kind = REQ_DRAIN;
    q.addr = '0;
    q.data = '0;
    pending_reqs.insert(pending_reqs.size(), q);
  endtask

  task automatic queue_random_vertex();
    queue_vertex(rand_pos_comp(), rand_pos_comp(), rand_pos_comp(),
                 rand_nrm_comp(), rand_nrm_comp(), rand_nrm_comp());
  endtask

  // driver: one request per handshake, with gaps after vertex requests
  int gap = 0;
  int quiet = 0;
  always @(negedge clk) begin
    logic nv, ncv;
    request_t h;
    if (rst_n) begin
      if (!((in_bus.valid && !in_acc) || (cfg_bus.valid && !cfg_acc))) begin
        nv = 1'b0;
        ncv = 1'b0;
        if (gap > 0) begin
          gap--;
        end else if (pending_reqs.size() > 0) begin
          h = pending_reqs[0];
          case (h.kind)
            REQ_VERTEX: begin
              void'(pending_reqs.pop_front());
              in_bus.pos_in_x <= h.vtx.pos[0];
              in_bus.pos_in_y <= h.vtx.pos[1];
              in_bus.pos_in_z <= h.vtx.pos[2];
              in_bus.nrm_in_x <= h.vtx.nrm[0];
              in_bus.nrm_in_y <= h.vtx.nrm[1];
              in_bus.nrm_in_z <= h.vtx.nrm[2];
              nv = 1'b1;
              gap = pick_gap();
            end
            REQ_CFG: begin
              void'(pending_reqs.pop_front());
              cfg_bus.addr <= h.addr;
              cfg_bus.data <= h.data;
              ncv = 1'b1;
            end
            default: begin
              // hold off until the pipeline has fully drained
              if (expected_vertices.size() == 0) begin
                quiet++;
                if (quiet >= QUIET_CYCLES) begin
                  quiet = 0;
                  void'(pending_reqs.pop_front());
                end
              end else begin
                quiet = 0;
              end
            end
          endcase
        end
        in_bus.valid <= nv;
        cfg_bus.valid <= ncv;
      end
    end
  end

  // receiver ready, with one long hold-off early in a random phase
  int out_gap = 0;
  int hold = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold > 0) begin
      hold--;
      out_bus.ready <= 1'b0;
    end else if (!hold_done && vertices_checked >= 180) begin
      hold_done = 1'b1;
      hold = HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_bus.ready <= 1'b0;
    end else begin
      out_gap = pick_gap();
      out_bus.ready <= 1'b1;
    end
  end

  // predictor and checker, sampled at the rising edge
  int idle_cycles = 0;
  always @(posedge clk) begin
    vertex_t w, e;
    in_acc <= rst_n && in_bus.valid && in_bus.ready;
    cfg_acc <= rst_n && cfg_bus.valid && cfg_bus.ready;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        cfg_writes++;
        case (cfg_bus.addr)
          REG_ROW_X: mat_rows[0] = cfg_bus.data;
          REG_ROW_Y: mat_rows[1] = cfg_bus.data;
          REG_ROW_Z: mat_rows[2] = cfg_bus.data;
          REG_OFF_X: translation[0] = cfg_bus.data[POS_W-1:0];
          REG_OFF_Y: translation[1] = cfg_bus.data[POS_W-1:0];
          REG_OFF_Z: translation[2] = cfg_bus.data[POS_W-1:0];
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        w.pos[0] = in_bus.pos_in_x; w.pos[1] = in_bus.pos_in_y; w.pos[2] = in_bus.pos_in_z;
        w.nrm[0] = in_bus.nrm_in_x; w.nrm[1] = in_bus.nrm_in_y; w.nrm[2] = in_bus.nrm_in_z;
        expected_vertices.insert(expected_vertices.size(), transform_vertex(w));
        vertices_sent++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_vertices.size() == 0) begin
          report_mismatch("unexpected result, pos_out_x", $signed(out_bus.pos_out_x), 0);
        end else begin
          e = expected_vertices.pop_front();
          if (out_bus.pos_out_x !== e.pos[0])
            report_mismatch("pos_out_x", $signed(out_bus.pos_out_x), e.pos[0]);
          if (out_bus.pos_out_y !== e.pos[1])
            report_mismatch("pos_out_y", $signed(out_bus.pos_out_y), e.pos[1]);
          if (out_bus.pos_out_z !== e.pos[2])
            report_mismatch("pos_out_z", $signed(out_bus.pos_out_z), e.pos[2]);
          if (out_bus.nrm_out_x !== e.nrm[0])
            report_mismatch("nrm_out_x", $signed(out_bus.nrm_out_x), e.nrm[0]);
          if (out_bus.nrm_out_y !== e.nrm[1])
            report_mismatch("nrm_out_y", $signed(out_bus.nrm_out_y), e.nrm[1]);
          if (out_bus.nrm_out_z !== e.nrm[2])
            report_mismatch("nrm_out_z", $signed(out_bus.nrm_out_z), e.nrm[2]);
        end
        vertices_checked++;
      end
      // watchdog on cycles with no handshake anywhere
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready) || (stim_done && expected_vertices.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [15:0] c[9];
    in_bus.valid = 1'b0;
    in_bus.pos_in_x = '0; in_bus.pos_in_y = '0; in_bus.pos_in_z = '0;
    in_bus.nrm_in_x = '0; in_bus.nrm_in_y = '0; in_bus.nrm_in_z = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.addr = '0;
    cfg_bus.data = '0;
    out_bus.ready = 1'b0;
    mat_rows[0] = ROW_X_RST; mat_rows[1] = ROW_Y_RST; mat_rows[2] = ROW_Z_RST;
    translation[0] = '0; translation[1] = '0; translation[2] = '0;

    // identity after reset: field extremes, zero and tiny normals
    queue_vertex(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0);
    queue_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 16'h4000, 16'h0, 16'h0);
    queue_vertex(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 16'hc000, 16'hc000, 16'h4000);
    queue_vertex(32'h1234_5678, 32'hedcb_a988, 32'h1, 16'h1, 16'h0, 16'h0);
    queue_vertex(32'hffff_0000, 32'h0000_8000, 32'h0000_0800, 16'h0, 16'hffff, 16'h2);
    queue_vertex(32'h5555_5555, 32'haaaa_aaaa, 32'h0, 16'h7fff, 16'h8000, 16'h0001);
    queue_vertex(32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000);
    queue_vertex(32'h0, 32'h0, 32'h0, 16'h2d41, 16'hd2bf, 16'h0000);
    // overflow through the translation, and a write to an unused index
    queue_drain();
    queue_cfg(REG_OFF_X, 48'hffff_7fff_ffff);
    queue_cfg(REG_OFF_Y, 48'h0000_8000_0000);
    queue_cfg(REG_OFF_Z, 48'h0000_0001_0000);
    queue_cfg(REG_UNUSED, 48'h1111_2222_3333);
    queue_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h4000, 16'h4000, 16'h4000);
    queue_vertex(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h1);
    queue_vertex(32'h0000_0001, 32'hffff_ffff, 32'h8000_0000, 16'hc000, 16'h0, 16'h0);
    // largest positive coefficients, then most negative
    queue_drain();
    queue_cfg(REG_ROW_X, 48'h7fff_7fff_7fff);
    queue_cfg(REG_ROW_Y, 48'h8000_8000_8000);
    queue_cfg(REG_ROW_Z, 48'h7fff_8000_7fff);
    queue_cfg(REG_OFF_X, 48'h0);
    queue_cfg(REG_OFF_Y, 48'h0);
    queue_cfg(REG_OFF_Z, 48'h0000_8000_0000);
    queue_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h4000, 16'h4000, 16'h4000);
    queue_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hc000, 16'hc000, 16'hc000);
    queue_vertex(32'h0001_0000, 32'hffff_0000, 32'h0, 16'h8000, 16'h7fff, 16'h8000);
    queue_vertex(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0);
    // all-zero matrix: every normal collapses
    queue_drain();
    queue_cfg(REG_ROW_X, 48'h0);
    queue_cfg(REG_ROW_Y, 48'h0);
    queue_cfg(REG_ROW_Z, 48'h0);
    queue_vertex(32'h7fff_ffff, 32'h1, 32'h8000_0000, 16'h4000, 16'hc000, 16'h1234);
    queue_vertex(32'h1, 32'h2, 32'h3, 16'h7fff, 16'h7fff, 16'h7fff);

    // random phases, each under its own register settings
    for (int ph = 0; ph < 10; ph++) begin
      queue_drain();
      for (int k = 0; k < 9; k++) c[k] = rand_coef((ph % 3 == 2) ? $urandom_range(0, 2) : ph % 2);
      queue_cfg(REG_ROW_X, {c[2], c[1], c[0]});
      queue_cfg(REG_ROW_Y, {c[5], c[4], c[3]});
      queue_cfg(REG_ROW_Z, {c[8], c[7], c[6]});
      queue_cfg(REG_OFF_X, {16'($urandom), 32'($urandom)});
      queue_cfg(REG_OFF_Y, {16'($urandom), rand_pos_comp()});
      queue_cfg(REG_OFF_Z, {16'($urandom), rand_pos_comp()});
      if (ph == 4) queue_cfg(REG_UNUSED + 3'd1, {16'($urandom), 32'($urandom)});
      for (int n = 0; n < 78; n++) queue_random_vertex();
    end
    // back to the identity matrix for a closing burst without idling
    queue_drain();
    queue_cfg(REG_ROW_X, ROW_X_RST);
    queue_cfg(REG_ROW_Y, ROW_Y_RST);
    queue_cfg(REG_ROW_Z, ROW_Z_RST);
    for (int n = 0; n < 40; n++) queue_random_vertex();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // last stretch runs without idling on either side
    while (pending_reqs.size() > 41) @(posedge clk);
    stall_phase = 1;
    while (pending_reqs.size() > 0 || in_bus.valid || cfg_bus.valid) @(posedge clk);
    stim_done = 1'b1;
    while (expected_vertices.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("checked %0d of %0d vertices over %0d register writes", vertices_checked,
             vertices_sent, cfg_writes);
    $display("predicted %0d clamped position components and %0d floored normals",
             clamped_positions, floored_normals);
    if (errors == 0 && expected_vertices.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
